[sv/scld_pkg.sv]
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types, codes and constants for the serial command line decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

  localparam int unsigned LINE_LIMIT_DEF = 30;

  localparam logic [15:0] MAX_RATE_RST = 16'd1000;
  localparam logic [31:0] SAT_MAG      = 32'h8000_0000;
  localparam logic [31:0] POS_MAX      = 32'h7FFF_FFFF;

  // ASCII codes
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_M     = 8'h4D;
  localparam logic [7:0] CHR_F     = 8'h46;
  localparam logic [7:0] CHR_R     = 8'h52;
  localparam logic [7:0] CHR_B     = 8'h42;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_C     = 8'h43;
  localparam logic [7:0] CHR_T     = 8'h54;
  localparam logic [7:0] CHR_Q     = 8'h51;
  localparam logic [7:0] CHR_Z     = 8'h5A;

  typedef enum logic [3:0] {
    CMD_SET_POWER = 4'd0,
    CMD_FORWARD   = 4'd1,
    CMD_REVERSE   = 4'd2,
    CMD_BRAKE     = 4'd3,
    CMD_COAST     = 4'd4,
    CMD_SET_RATE  = 4'd5,
    CMD_QUERY     = 4'd6,
    CMD_TARE      = 4'd7,
    CMD_UNKNOWN   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_t;

  // Parser result handed to the output register
  typedef struct packed {
    logic        emit;
    cmd_t        command;
    logic [31:0] value;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CHR_SP) || (c == CHR_TAB) || (c == CHR_VT) || (c == CHR_FF);
  endfunction

endpackage

[sv/scld_ifs.sv]
// ----------------------------------------------------------------------------
// scld channel interfaces
// Valid/ready channels for received bytes and decoded commands.
// ----------------------------------------------------------------------------
interface scld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scld_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

[sv/serial_command_line_decoder_unit.sv]
// ----------------------------------------------------------------------------
// serial_command_line_decoder_unit
// Assembles received bytes into command lines and emits a command code and
// argument at each line end.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_bus    in   valid/ready    rx_byte  [7:0]
//  out_bus   out  valid/ready    command  [3:0], value [31:0] signed
//  cfg_*     in   cfg_we         cfg_wdata [15:0] -> max_rate
//
//  One byte request per cycle while out_bus is not stalled; a result shows
//  on out_bus once the line-end byte has passed the input register and then
//  the parser into the result register.
//  Reset (rst_n low, synchronous) empties both registers, clears the line
//  state and sets max_rate to 1000.
//  A stalled result holds the parser and any byte in the input register;
//  the input register then takes a byte only while it is empty.
// ----------------------------------------------------------------------------
module serial_command_line_decoder_unit import scld_pkg::*; #(
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  scld_byte_if.sink   in_bus,
  scld_cmd_if.source  out_bus,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic       in_vld;
  logic [7:0] rx_q;
  logic       hold;
  logic       advance;
  result_t    res;

  // byte moves through the parser whenever the result register can take
  // whatever it produces
  assign advance = in_vld && !hold;

  scld_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .advance (advance),
    .vld     (in_vld),
    .rx_q    (rx_q)
  );

  // line state, number accumulate and decode; the result is combinational
  scld_line_parser #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .rx_q      (rx_q),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  scld_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance),
    .res     (res),
    .out_bus (out_bus),
    .hold    (hold)
  );

endmodule

[sv/scld_in_stage.sv]
// ----------------------------------------------------------------------------
// scld_in_stage
// Input register: captures one byte request, frees as the parser consumes it.
// ----------------------------------------------------------------------------
module scld_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  scld_byte_if.sink   in_bus,
  input  logic        advance,
  output logic        vld,
  output logic [7:0]  rx_q
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] rx_r;
  logic       take;

  assign in_bus.ready = !vld_r || advance;
  assign take         = in_bus.valid && in_bus.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rx_r <= in_bus.rx_byte;
    end
  end

  assign vld  = vld_r;
  assign rx_q = rx_r;

endmodule

[sv/scld_line_parser.sv]
// ----------------------------------------------------------------------------
// scld_line_parser
// Line state, letter/comma tracking, decimal accumulate and command decode.
// ----------------------------------------------------------------------------
module scld_line_parser import scld_pkg::*; #(
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  rx_q,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output result_t     res
);

  localparam int unsigned LEN_W = $clog2(LINE_LIMIT + 1);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       letter_r, letter_nxt;
  logic             letter_seen_r, letter_seen_nxt;
  logic             comma_seen_r, comma_seen_nxt;
  num_phase_t       phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic [15:0]      max_rate_r;

  logic        is_eol, blank, digit, is_comma, is_sign;
  logic [35:0] prod;
  logic [31:0] mag_acc;
  cmd_t        code;
  logic        needs_arg;
  logic [31:0] sval, rval, rate_ext;

  assign is_eol   = (rx_q == CHR_LF) || (rx_q == CHR_CR);
  assign blank    = is_blank(rx_q);
  assign digit    = (rx_q >= CHR_0) && (rx_q <= CHR_9);
  assign is_comma = (rx_q == CHR_COMMA);
  assign is_sign  = (rx_q == CHR_PLUS) || (rx_q == CHR_MINUS);

  // mag * 10 + digit, saturating at 2^31
  assign prod    = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1) + {32'd0, rx_q[3:0]};
  assign mag_acc = (prod >= {4'd0, SAT_MAG}) ? SAT_MAG : prod[31:0];

  assign rate_ext = {16'd0, max_rate_r};
  assign sval = neg_r ? ((mag_r >= SAT_MAG) ? SAT_MAG : (32'd0 - mag_r))
                      : ((mag_r >= SAT_MAG) ? POS_MAX : mag_r);
  assign rval = (neg_r && (mag_r != 32'd0)) ? 32'd0
              : ((mag_r > rate_ext) ? rate_ext : mag_r);

  always_comb begin
    code      = CMD_UNKNOWN;
    needs_arg = 1'b0;
    case (letter_r)
      CHR_M:   begin code = CMD_SET_POWER; needs_arg = 1'b1; end
      CHR_F:   begin code = CMD_FORWARD;   needs_arg = 1'b1; end
      CHR_R:   begin code = CMD_REVERSE;   needs_arg = 1'b1; end
      CHR_B:   code = CMD_BRAKE;
      CHR_S:   code = CMD_BRAKE;
      CHR_C:   code = CMD_COAST;
      CHR_T:   begin code = CMD_SET_RATE;  needs_arg = 1'b1; end
      CHR_Q:   code = CMD_QUERY;
      CHR_Z:   code = CMD_TARE;
      default: code = CMD_UNKNOWN;
    endcase
  end

  always_comb begin
    len_nxt         = len_r;
    letter_nxt      = letter_r;
    letter_seen_nxt = letter_seen_r;
    comma_seen_nxt  = comma_seen_r;
    phase_nxt       = phase_r;
    neg_nxt         = neg_r;
    mag_nxt         = mag_r;
    res.emit        = 1'b0;
    res.command     = code;
    res.value       = 32'd0;
    if (fire) begin
      if (!is_eol) begin
        if (len_r < LEN_W'(LINE_LIMIT)) begin
          len_nxt = len_r + LEN_W'(1);
          if (!letter_seen_r) begin
            if (!blank) begin
              letter_nxt      = rx_q;
              letter_seen_nxt = 1'b1;
              comma_seen_nxt  = is_comma;
            end
          end else if (!comma_seen_r) begin
            comma_seen_nxt = is_comma;
          end else begin
            case (phase_r)
              NUM_SKIP: begin
                if (is_sign) begin
                  neg_nxt   = (rx_q == CHR_MINUS);
                  phase_nxt = NUM_DIGITS;
                end else if (digit) begin
                  mag_nxt   = mag_acc;
                  phase_nxt = NUM_DIGITS;
                end else if (!blank) begin
                  phase_nxt = NUM_DONE;
                end
              end
              NUM_DIGITS: begin
                if (digit) begin
                  mag_nxt = mag_acc;
                end else begin
                  phase_nxt = NUM_DONE;
                end
              end
              default: ;
            endcase
          end
        end
      end else begin
        // line end: result if a letter was seen and any needed comma is there
        res.emit = letter_seen_r && (!needs_arg || comma_seen_r);
        if (needs_arg) begin
          res.value = (code == CMD_SET_RATE) ? rval : sval;
        end
        len_nxt         = '0;
        letter_nxt      = 8'd0;
        letter_seen_nxt = 1'b0;
        comma_seen_nxt  = 1'b0;
        phase_nxt       = NUM_SKIP;
        neg_nxt         = 1'b0;
        mag_nxt         = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r         <= '0;
      letter_r      <= 8'd0;
      letter_seen_r <= 1'b0;
      comma_seen_r  <= 1'b0;
      phase_r       <= NUM_SKIP;
      neg_r         <= 1'b0;
      mag_r         <= 32'd0;
      max_rate_r    <= MAX_RATE_RST;
    end else begin
      len_r         <= len_nxt;
      letter_r      <= letter_nxt;
      letter_seen_r <= letter_seen_nxt;
      comma_seen_r  <= comma_seen_nxt;
      phase_r       <= phase_nxt;
      neg_r         <= neg_nxt;
      mag_r         <= mag_nxt;
      if (cfg_we) begin
        max_rate_r <= cfg_wdata;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(LINE_LIMIT))
    else $error("line length past limit");

  a_mag_sat: assert property (@(posedge clk) disable iff (!rst_n)
    mag_r <= SAT_MAG)
    else $error("magnitude past saturation");

  a_comma_order: assert property (@(posedge clk) disable iff (!rst_n)
    comma_seen_r |-> letter_seen_r)
    else $error("comma seen without letter");

  a_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != NUM_SKIP) || neg_r || (mag_r != 32'd0) |-> comma_seen_r)
    else $error("number state without comma");

  a_eol_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_eol |=> (len_r == '0) && !letter_seen_r && (mag_r == 32'd0))
    else $error("line state not cleared at line end");
`endif

endmodule

[sv/scld_out_stage.sv]
// ----------------------------------------------------------------------------
// scld_out_stage
// Result register: holds a decoded command until the sink takes it.
// ----------------------------------------------------------------------------
module scld_out_stage import scld_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  scld_cmd_if.source  out_bus,
  output logic        hold
);

  logic        vld_r, vld_nxt;
  cmd_t        cmd_r;
  logic [31:0] val_r;
  logic        put;

  assign put = load && res.emit;

  always_comb begin
    vld_nxt = vld_r;
    if (put) begin
      vld_nxt = 1'b1;
    end else if (out_bus.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      cmd_r <= res.command;
      val_r <= res.value;
    end
  end

  assign hold            = vld_r && !out_bus.ready;
  assign out_bus.valid   = vld_r;
  assign out_bus.command = cmd_r;
  assign out_bus.value   = val_r;

endmodule

[sim/serial_command_line_decoder_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_command_line_decoder_unit_tb
// Feeds byte requests into the command line decoder and checks every decoded
// command against an in-bench line parser. Directed lines are followed by
// random lines under several max_rate settings. Both channels idle at random,
// and one long output stall backs the decoder up onto its input.
// ----------------------------------------------------------------------------
module serial_command_line_decoder_unit_tb;
  import scld_pkg::*;

  localparam int unsigned LINE_MAX       = LINE_LIMIT_DEF;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned DRAIN_CYCLES   = 6;     // two-stage pipe plus margin
  localparam int unsigned LONG_HOLD      = 400;   // output stall for back-pressure
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no request moving
  localparam int unsigned RANDOM_BYTES   = 300;
  localparam int unsigned RATE_PHASES    = 4;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] value;
  } cmd_word_t;

  // --------------------------------------------------------------------------
  // Line parser and store of expected commands
  // --------------------------------------------------------------------------
  class cmd_line_scoreboard;
    logic [15:0] rate_cap;
    logic [4:0]  kept_len;
    logic [7:0]  lead_char;
    bit          have_letter;
    bit          have_comma;
    num_phase_t  arg_phase;
    bit          arg_neg;
    logic [31:0] arg_mag;
    cmd_word_t   pending_cmds[$];
    int unsigned cmds_checked;
    int unsigned errors;
    bit [8:0]    codes_seen;

    function new();
      rate_cap     = MAX_RATE_RST;
      cmds_checked = 0;
      errors       = 0;
      codes_seen   = '0;
      clear_line();
    endfunction

    function void clear_line();
      kept_len    = '0;
      lead_char   = '0;
      have_letter = 1'b0;
      have_comma  = 1'b0;
      arg_phase   = NUM_SKIP;
      arg_neg     = 1'b0;
      arg_mag     = '0;
    endfunction

    function bit blank_char(logic [7:0] c);
      case (c)
        CHR_SP, CHR_TAB, CHR_VT, CHR_FF: return 1'b1;
        default:                         return 1'b0;
      endcase
    endfunction

    function void add_digit(logic [7:0] c);
      logic [63:0] acc;
      acc = {32'd0, arg_mag} * 64'd10 + {56'd0, c - CHR_0};
      arg_mag = (acc >= {32'd0, SAT_MAG}) ? SAT_MAG : acc[31:0];
    endfunction

    function void feed_arg(logic [7:0] c);
      bit digit;
      digit = (c >= CHR_0) && (c <= CHR_9);
      case (arg_phase)
        NUM_SKIP: begin
          if (!blank_char(c)) begin
            if (c == CHR_PLUS || c == CHR_MINUS) begin
              arg_neg   = (c == CHR_MINUS);
              arg_phase = NUM_DIGITS;
            end else if (digit) begin
              add_digit(c);
              arg_phase = NUM_DIGITS;
            end else begin
              arg_phase = NUM_DONE;
            end
          end
        end
        NUM_DIGITS: begin
          if (digit) add_digit(c);
          else arg_phase = NUM_DONE;
        end
        default: ;
      endcase
    endfunction

    // One accepted byte request; a line end may queue one command.
    function void note_byte(logic [7:0] c);
      cmd_word_t res;
      bit        with_arg;
      if (c != CHR_LF && c != CHR_CR) begin
        if (kept_len >= LINE_MAX) return;
        kept_len = kept_len + 5'd1;
        if (!have_letter) begin
          if (!blank_char(c)) begin
            lead_char   = c;
            have_letter = 1'b1;
            if (c == CHR_COMMA) have_comma = 1'b1;
          end
        end else if (!have_comma) begin
          if (c == CHR_COMMA) have_comma = 1'b1;
        end else begin
          feed_arg(c);
        end
        return;
      end
      if (!have_letter) begin
        clear_line();
        return;
      end
      with_arg = 1'b0;
      case (lead_char)
        CHR_M: begin res.command = CMD_SET_POWER; with_arg = 1'b1; end
        CHR_F: begin res.command = CMD_FORWARD;   with_arg = 1'b1; end
        CHR_R: begin res.command = CMD_REVERSE;   with_arg = 1'b1; end
        CHR_T: begin res.command = CMD_SET_RATE;  with_arg = 1'b1; end
        CHR_B, CHR_S: res.command = CMD_BRAKE;
        CHR_C: res.command = CMD_COAST;
        CHR_Q: res.command = CMD_QUERY;
        CHR_Z: res.command = CMD_TARE;
        default: res.command = CMD_UNKNOWN;
      endcase
      res.value = '0;
      if (with_arg) begin
        if (!have_comma) begin
          clear_line();
          return;
        end
        if (res.command == CMD_SET_RATE) begin
          if (arg_neg && arg_mag != 0) res.value = '0;
          else if (arg_mag > {16'd0, rate_cap}) res.value = {16'd0, rate_cap};
          else res.value = arg_mag;
        end else if (arg_neg) begin
          res.value = (arg_mag >= SAT_MAG) ? SAT_MAG : -arg_mag;
        end else begin
          res.value = (arg_mag >= SAT_MAG) ? POS_MAX : arg_mag;
        end
      end
      pending_cmds.push_back(res);
      clear_line();
    endfunction

    function void check_cmd(logic [3:0] cmd, logic signed [31:0] val);
      cmd_word_t want;
      cmds_checked++;
      if (pending_cmds.size() == 0) begin
        errors++;
        $error("command %0d value %0d arrived with nothing pending", cmd, val);
        return;
      end
      want = pending_cmds.pop_front();
      codes_seen[want.command] = 1'b1;
      if (cmd !== want.command) begin
        errors++;
        $error("command mismatch: expected %0d, got %0d", want.command, cmd);
      end
      if (val !== want.value) begin
        errors++;
        $error("value mismatch: expected %0d, got %0d", want.value, val);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and channels
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  scld_byte_if byte_bus();
  scld_cmd_if  cmd_bus();

  serial_command_line_decoder_unit #(
    .LINE_LIMIT(LINE_MAX)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (byte_bus),
    .out_bus  (cmd_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  cmd_line_scoreboard sb;
  logic [7:0]  line_buf[$];
  bit          steady_flow = 1'b0;  // no idling on either side while set
  bit          hold_req    = 1'b0;  // asks the receiver for one long stall
  int unsigned sent_bytes  = 0;
  int unsigned rate_writes = 0;
  int unsigned stuck_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitors sample at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (byte_bus.valid && byte_bus.ready) sb.note_byte(byte_bus.rx_byte);
      if (cmd_bus.valid && cmd_bus.ready) sb.check_cmd(cmd_bus.command, cmd_bus.value);
    end
  end

  // Watchdog: any request moving on either side restarts the count.
  always @(posedge clk) begin
    if ((byte_bus.valid && byte_bus.ready) || (cmd_bus.valid && cmd_bus.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CHR_SP;
      1:       return CHR_TAB;
      2:       return CHR_VT;
      default: return CHR_FF;
    endcase
  endfunction

  // Any byte that does not end the line.
  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHR_LF || b == CHR_CR);
    return b;
  endfunction

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 8))
      0:       return CHR_M;
      1:       return CHR_F;
      2:       return CHR_R;
      3:       return CHR_B;
      4:       return CHR_S;
      5:       return CHR_C;
      6:       return CHR_T;
      7:       return CHR_Q;
      default: return CHR_Z;
    endcase
  endfunction

  // Receiver: random ready gaps, plus the one long hold when asked.
  initial begin
    int unsigned gap;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        cmd_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = steady_flow ? 0 : pick_gap();
        if (gap != 0) begin
          cmd_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        cmd_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // One byte request; valid stays up when the next one follows at once.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = steady_flow ? 0 : pick_gap();
    if (gap != 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_bus.valid   <= 1'b1;
    byte_bus.rx_byte <= b;
    do @(posedge clk); while (!byte_bus.ready);
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_buf();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  // Drain: all commands back, then let any trailing byte clear the pipe.
  // The first wait lets the monitor note the last accepted byte.
  task automatic wait_idle();
    byte_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [15:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.rate_cap = v;
    rate_writes++;
  endtask

  // Random line: mostly well formed with random content, the rest noise.
  task automatic build_line();
    int unsigned r;
    int unsigned n;
    line_buf.delete();
    if ($urandom_range(0, 99) < 82) begin
      repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
      if ($urandom_range(0, 99) < 85) line_buf.push_back(pick_letter());
      else line_buf.push_back(pick_plain());
      if ($urandom_range(0, 99) < 20) line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
      if ($urandom_range(0, 99) < 90) line_buf.push_back(CHR_COMMA);
      repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
      r = $urandom_range(0, 99);
      if (r < 30) line_buf.push_back(CHR_MINUS);
      else if (r < 45) line_buf.push_back(CHR_PLUS);
      // digit count: now and then enough to saturate
      r = $urandom_range(0, 99);
      n = (r < 10) ? 0 : (r < 80) ? $urandom_range(1, 5) :
          (r < 90) ? $urandom_range(6, 9) : $urandom_range(10, 12);
      repeat (n) line_buf.push_back(CHR_0 + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 99) < 20) line_buf.push_back(pick_plain());
      // long tail that can run past the line limit
      if ($urandom_range(0, 99) < 6)
        repeat ($urandom_range(25, 35)) line_buf.push_back(pick_plain());
    end else begin
      repeat ($urandom_range(0, 40)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    line_buf.push_back(($urandom_range(0, 99) < 70) ? CHR_LF : CHR_CR);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_start;
    logic [15:0] rate;
    sb = new();
    rst_n            <= 1'b0;
    byte_bus.valid   <= 1'b0;
    byte_bus.rx_byte <= 8'h00;
    cmd_bus.ready    <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 16'h0000;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines, max_rate still at its reset value.
    send_text("M,100\n");
    send_text("F,-25"); send_byte(CHR_CR);
    send_text("R,+7\n");
    send_text("B\n");
    send_text("S\n");
    send_text("C\n");
    send_text("T,500\n");
    send_text("Q\n");
    send_text("Z\n");
    send_text("X\n");                      // unknown letter
    send_text("\n");                       // empty line
    send_byte(CHR_SP); send_byte(CHR_TAB); // whitespace only
    send_byte(CHR_VT); send_byte(CHR_FF); send_byte(CHR_CR);
    send_text("M\n");                      // argument command, no comma
    send_text("F, abc\n");                 // no digits after comma
    send_text("R,99999999999\n");          // saturates high
    send_text("M,-99999999999\n");         // saturates low
    send_text("M,-2147483648\n");
    send_text("F,2147483647\n");
    send_text("T,-5\n");                   // negative rate
    send_text("T,-0\n");
    send_text("T,70000\n");                // clamps to max_rate
    send_text(",5\n");                     // comma as the letter
    send_byte(8'h00); send_text(",3\n");   // NUL letter
    send_byte(8'hFF); send_text("\n");
    // comma is the last kept byte, digits are dropped
    send_text("M"); repeat (28) send_byte(CHR_SP); send_text(",56\n");
    // comma itself is dropped, so the line says nothing
    send_text("T"); repeat (29) send_byte(CHR_SP); send_text(",5\n");

    // Random lines across max_rate settings, extremes included.
    for (int p = 0; p < RATE_PHASES; p++) begin
      case (p)
        0:       rate = 16'h0000;
        1:       rate = 16'hFFFF;
        2:       rate = 16'($urandom_range(1, 65534));
        default: rate = 16'($urandom_range(1, 20));
      endcase
      write_rate(rate);
      steady_flow = (p == 1);
      phase_start = sent_bytes;
      if (p == 2) begin
        // receiver holds off while short commands pile up behind it
        hold_req = 1'b1;
        repeat (16) begin
          if ($urandom_range(0, 1) != 0) send_text("Q\n");
          else send_text("B\n");
        end
      end
      while (sent_bytes - phase_start < RANDOM_BYTES / RATE_PHASES) begin
        build_line();
        send_buf();
      end
    end
    steady_flow = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d bytes fed, %0d commands checked, %0d max_rate writes",
             sent_bytes, sb.cmds_checked, rate_writes);
    $display("Command codes seen (bit per code): %b", sb.codes_seen);
    if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (sb.pending_cmds.size() != 0)
        $error("%0d expected commands never arrived", sb.pending_cmds.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
